### src/slcfr_pkg.sv
// package: types, codes and reset constants for the frame receiver
`default_nettype none
package slcfr_pkg;

    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [15:0] TimeoutTicksReset = 16'd1000;
    localparam logic [15:0] ChecksumSeedReset = 16'hAB34;
    localparam logic [7:0]  FirstSyncReset    = 8'h41;
    localparam logic [7:0]  SecondSyncReset   = 8'h54;

    localparam logic [CfgIndexW-1:0] RegTimeoutTicks = 2'd0;
    localparam logic [CfgIndexW-1:0] RegChecksumSeed = 2'd1;
    localparam logic [CfgIndexW-1:0] RegFirstSync    = 2'd2;
    localparam logic [CfgIndexW-1:0] RegSecondSync   = 2'd3;

    localparam logic [15:0] TickMax = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SYNC1    = 3'd1,
        PH_COMMAND  = 3'd2,
        PH_LENGTH   = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_SUM_HIGH = 3'd5,
        PH_SUM_LOW  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_TIMEOUT   = 2'd2
    } t_kind;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic       sum_ok;
    } t_out_item;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] checksum_seed;
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
    } t_cfg;

endpackage
`default_nettype wire

### src/slcfr_cfg_regs.sv
// configuration registers of the frame receiver
`default_nettype none
module slcfr_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [slcfr_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [slcfr_pkg::CfgDataW-1:0]  i_cfg_data,
    output slcfr_pkg::t_cfg                     o_cfg
);

    slcfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= slcfr_pkg::TimeoutTicksReset;
            r_cfg.checksum_seed <= slcfr_pkg::ChecksumSeedReset;
            r_cfg.first_sync    <= slcfr_pkg::FirstSyncReset;
            r_cfg.second_sync   <= slcfr_pkg::SecondSyncReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slcfr_pkg::RegTimeoutTicks: r_cfg.timeout_ticks <= i_cfg_data;
                slcfr_pkg::RegChecksumSeed: r_cfg.checksum_seed <= i_cfg_data;
                slcfr_pkg::RegFirstSync:    r_cfg.first_sync    <= i_cfg_data[7:0];
                slcfr_pkg::RegSecondSync:   r_cfg.second_sync   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### src/slcfr_parser.sv
// frame parser: phase register, running sum, tick timer and result decode
`default_nettype none
module slcfr_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire slcfr_pkg::t_cfg      i_cfg,
    input  wire logic                 i_en,
    input  wire slcfr_pkg::t_in_item  i_item,
    output logic                      o_res_valid,
    output slcfr_pkg::t_out_item      o_res
);

    slcfr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_running_sum, n_running_sum;
    logic [15:0] r_received_sum, n_received_sum;
    logic [7:0]  r_held_command, n_held_command;
    logic [7:0]  r_held_length, n_held_length;
    logic [7:0]  r_bytes_seen, n_bytes_seen;
    logic [15:0] r_tick_count, n_tick_count;
    logic        r_timer_active, n_timer_active;
    logic        r_timeout_pending, n_timeout_pending;

    logic [7:0]  b;
    logic [15:0] sum_plus_b;
    logic [15:0] tick_inc;
    logic [7:0]  seen_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= slcfr_pkg::PH_IDLE;
            r_running_sum     <= '0;
            r_received_sum    <= '0;
            r_held_command    <= '0;
            r_held_length     <= '0;
            r_bytes_seen      <= '0;
            r_tick_count      <= '0;
            r_timer_active    <= 1'b0;
            r_timeout_pending <= 1'b0;
        end else if (i_en) begin
            r_phase           <= n_phase;
            r_running_sum     <= n_running_sum;
            r_received_sum    <= n_received_sum;
            r_held_command    <= n_held_command;
            r_held_length     <= n_held_length;
            r_bytes_seen      <= n_bytes_seen;
            r_tick_count      <= n_tick_count;
            r_timer_active    <= n_timer_active;
            r_timeout_pending <= n_timeout_pending;
        end
    end

    assign b          = i_item.rx_byte;
    assign sum_plus_b = r_running_sum + {8'd0, b};
    assign tick_inc   = (r_tick_count < slcfr_pkg::TickMax) ? r_tick_count + 16'd1
                                                           : r_tick_count;
    assign seen_inc   = r_bytes_seen + 8'd1;

    always_comb begin
        n_phase           = r_phase;
        n_running_sum     = r_running_sum;
        n_received_sum    = r_received_sum;
        n_held_command    = r_held_command;
        n_held_length     = r_held_length;
        n_bytes_seen      = r_bytes_seen;
        n_tick_count      = r_tick_count;
        n_timer_active    = r_timer_active;
        n_timeout_pending = r_timeout_pending;
        o_res_valid       = 1'b0;
        o_res             = '0;

        if (i_item.mode == slcfr_pkg::MODE_TICK) begin
            // ticks only count while a frame is open
            if (r_timer_active) begin
                n_tick_count = tick_inc;
                if (tick_inc >= i_cfg.timeout_ticks) begin
                    n_phase           = slcfr_pkg::PH_IDLE;
                    n_timer_active    = 1'b0;
                    n_timeout_pending = 1'b1;
                end
            end
        end else begin
            case (r_phase)
                slcfr_pkg::PH_IDLE: begin
                    if (r_timeout_pending) begin
                        n_timeout_pending = 1'b0;
                        o_res_valid       = 1'b1;
                        o_res.kind        = slcfr_pkg::KIND_TIMEOUT;
                    end
                    if (b == i_cfg.first_sync) begin
                        n_phase = slcfr_pkg::PH_SYNC1;
                    end
                end
                slcfr_pkg::PH_SYNC1: begin
                    // second sync checked ahead of a repeated first sync
                    if (b == i_cfg.second_sync) begin
                        n_phase           = slcfr_pkg::PH_COMMAND;
                        n_bytes_seen      = '0;
                        n_running_sum     = i_cfg.checksum_seed;
                        n_tick_count      = '0;
                        n_timer_active    = 1'b1;
                        n_timeout_pending = 1'b0;
                    end else if (b != i_cfg.first_sync) begin
                        n_phase = slcfr_pkg::PH_IDLE;
                    end
                end
                slcfr_pkg::PH_COMMAND: begin
                    n_held_command = b;
                    n_running_sum  = sum_plus_b;
                    n_phase        = slcfr_pkg::PH_LENGTH;
                end
                slcfr_pkg::PH_LENGTH: begin
                    n_held_length = b;
                    n_running_sum = sum_plus_b;
                    n_phase       = (b == 8'd0) ? slcfr_pkg::PH_SUM_HIGH
                                                : slcfr_pkg::PH_PAYLOAD;
                end
                slcfr_pkg::PH_PAYLOAD: begin
                    n_running_sum       = sum_plus_b;
                    o_res_valid         = 1'b1;
                    o_res.kind          = slcfr_pkg::KIND_PAYLOAD;
                    o_res.payload_byte  = b;
                    o_res.payload_index = r_bytes_seen;
                    o_res.frame_command = r_held_command;
                    o_res.frame_length  = r_held_length;
                    n_bytes_seen        = seen_inc;
                    if (seen_inc == r_held_length) begin
                        n_phase = slcfr_pkg::PH_SUM_HIGH;
                    end
                end
                slcfr_pkg::PH_SUM_HIGH: begin
                    n_received_sum = {b, 8'd0};
                    n_phase        = slcfr_pkg::PH_SUM_LOW;
                end
                slcfr_pkg::PH_SUM_LOW: begin
                    n_received_sum      = {r_received_sum[15:8], b};
                    n_timer_active      = 1'b0;
                    o_res_valid         = 1'b1;
                    o_res.kind          = slcfr_pkg::KIND_FRAME_END;
                    o_res.frame_command = r_held_command;
                    o_res.frame_length  = r_held_length;
                    o_res.sum_ok        = ({r_received_sum[15:8], b} == r_running_sum);
                    n_phase             = slcfr_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = slcfr_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### src/sync_length_checksum_frame_receiver_core.sv
// top level of the sync, length and checksum frame receiver
// path: a request accepted into the input register leaves its result in the result
//   register at the edge at which the parser advances with it
// throughput: one request per cycle while the result channel does not stall, set by
//   the combinational parser between the input register and the result register
// reset: synchronous active-low, clears the parser state, both valid flags
//   and loads the configuration registers with their defaults
`default_nettype none
module sync_length_checksum_frame_receiver_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire slcfr_pkg::t_in_item             i_in,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output slcfr_pkg::t_out_item                 o_out,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [slcfr_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [slcfr_pkg::CfgDataW-1:0]  i_cfg_data
);

    // input register holds one request until the parser takes it
    logic                 r_in_valid;
    slcfr_pkg::t_in_item  r_in;

    // result register parts the parser from the downstream stall
    logic                 r_out_valid;
    slcfr_pkg::t_out_item r_out;

    slcfr_pkg::t_cfg      cfg;
    logic                 advance;
    logic                 in_accept;
    logic                 res_valid;
    slcfr_pkg::t_out_item res;

    slcfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // parser moves when it holds a request and the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    slcfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_en        (advance),
        .i_item      (r_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    // result stage control, ticks and silent bytes leave it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire
